FILE: rtl/integer_to_digits_any_base_macros.svh
// Assertion macros for the integer to digits conversion block.
`ifndef INTEGER_TO_DIGITS_ANY_BASE_MACROS_SVH
`define INTEGER_TO_DIGITS_ANY_BASE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ITDAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ITDAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITDAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ITDAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/itdab_pkg.sv
// Shared constants, types and arithmetic helpers for the digit conversion block.
`default_nettype none
package itdab_pkg;

    localparam int VALUE_W   = 64;
    localparam int NUM_BYTES = VALUE_W / 8;
    localparam int NBYTES_W  = $clog2(NUM_BYTES + 1);
    localparam int BIDX_W    = $clog2(NUM_BYTES);
    localparam int MAX_DIGITS = 64;
    localparam int MAX_RADIX  = 16;
    localparam int PTR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W     = PTR_W + 1;
    localparam int DIGIT_W   = 4;
    localparam int RADIX_W   = 5;
    localparam int CHAR_W    = 8;
    localparam int SYM_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;
    localparam logic [SYM_W-1:0]   SYM0_RST  = 32'h3332_3130;
    localparam logic [SYM_W-1:0]   SYM1_RST  = 32'h3736_3534;
    localparam logic [SYM_W-1:0]   SYM2_RST  = 32'h6261_3938;
    localparam logic [SYM_W-1:0]   SYM3_RST  = 32'h6665_6463;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX = 3'd0,
        CFG_SYM0  = 3'd1,
        CFG_SYM1  = 3'd2,
        CFG_SYM2  = 3'd3,
        CFG_SYM3  = 3'd4
    } t_cfg_idx;

    typedef logic [3:0][SYM_W-1:0] t_sym_tab;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic [DIGIT_W-1:0] digit;
    } t_div_stat;

    function automatic logic [RADIX_W-1:0] eff_radix(logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        e = r;
        if (e < RADIX_W'(2)) begin
            e = RADIX_W'(2);
        end
        if (e > RADIX_W'(MAX_RADIX)) begin
            e = RADIX_W'(MAX_RADIX);
        end
        return e;
    endfunction

    // Returns {quotient byte, remainder}.
    function automatic logic [CHAR_W+DIGIT_W-1:0] div_byte(logic [DIGIT_W-1:0] rem_in,
                                                           logic [7:0] byte_in,
                                                           logic [RADIX_W-1:0] rdx);
        logic [RADIX_W-1:0] t;
        logic [DIGIT_W-1:0] rem;
        logic [7:0]         q;
        rem = rem_in;
        q   = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {rem, byte_in[i]};
            if (t >= rdx) begin
                q[i] = 1'b1;
                t    = t - rdx;
            end
            rem = t[DIGIT_W-1:0];
        end
        return {q, rem};
    endfunction

    function automatic logic [CHAR_W-1:0] symbol_of(t_sym_tab tab, logic [DIGIT_W-1:0] d);
        logic [SYM_W-1:0] w;
        w = tab[d[3:2]];
        return w[{d[1:0], 3'b000} +: CHAR_W];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/itdab_div.sv
// Iterative divide-by-radix unit: one byte of the quotient per cycle.
`default_nettype none
module itdab_div
    import itdab_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_start,
    input  wire logic [RADIX_W-1:0] i_radix,
    output t_div_stat               o_stat
);

    logic [VALUE_W-1:0]  r_val;
    logic [NBYTES_W-1:0] r_nbytes;
    logic [BIDX_W-1:0]   r_idx;
    logic [DIGIT_W-1:0]  r_rem;
    logic                r_busy;
    logic                r_done;
    logic                r_top_zero;

    logic [CHAR_W+DIGIT_W-1:0] step;
    logic [CHAR_W-1:0]         step_q;
    logic [DIGIT_W-1:0]        step_rem;
    logic [NBYTES_W-1:0]       top_idx;

    assign step     = div_byte(r_rem, r_val[{r_idx, 3'b000} +: 8], i_radix);
    assign step_q   = step[CHAR_W+DIGIT_W-1:DIGIT_W];
    assign step_rem = step[DIGIT_W-1:0];
    assign top_idx  = r_nbytes - NBYTES_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_nbytes   <= NBYTES_W'(NUM_BYTES);
            r_idx      <= '0;
            r_rem      <= '0;
            r_top_zero <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_val    <= i_value;
                r_nbytes <= NBYTES_W'(NUM_BYTES);
                r_idx    <= BIDX_W'(NUM_BYTES - 1);
                r_rem    <= '0;
                r_busy   <= 1'b1;
            end else if (i_start) begin
                r_idx  <= top_idx[BIDX_W-1:0];
                r_rem  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_val[{r_idx, 3'b000} +: 8] <= step_q;
                r_rem <= step_rem;
                if (NBYTES_W'(r_idx) == top_idx) begin
                    r_top_zero <= (step_q == '0);
                end
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_nbytes > NBYTES_W'(1) && r_top_zero) begin
                        r_nbytes <= r_nbytes - NBYTES_W'(1);
                    end
                end else begin
                    r_idx <= r_idx - BIDX_W'(1);
                end
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.zero  = (r_val == '0);
    assign o_stat.digit = r_rem;

endmodule
`default_nettype wire

FILE: rtl/integer_to_digits_any_base.sv
// Top level: unsigned 64-bit integer to digit characters in a configurable base.
// Converts one 64-bit value at a time and emits its digits most significant first,
// one request per digit, each mapped through the 16-entry symbol table, the final
// digit flagged by o_last_digit; zero gives one symbol-0 digit. Bases outside 2..16
// are clamped to that range. Each digit costs one division pass through the shared
// byte-wide divider, which steps through B quotient bytes, where B is the count of
// bytes still carried (starts at 8, drops by at most one per digit as it shrinks).
// Emission then reads each digit back from the digit store through S_RD, S_LOAD and
// S_OUT, holding in S_OUT until i_ready is high. o_ready is high only while the
// block is idle.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
`default_nettype none
`include "integer_to_digits_any_base_macros.svh"
module integer_to_digits_any_base
    import itdab_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SYM_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [VALUE_W-1:0]   i_value,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [CHAR_W-1:0]         o_digit_char,
    output logic                      o_last_digit
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [RADIX_W-1:0]  r_radix;
    t_sym_tab            r_sym;
    logic [CNT_W-1:0]    r_cnt;
    logic [PTR_W-1:0]    r_ptr;
    logic [DIGIT_W-1:0]  r_rd_data;
    logic [DIGIT_W-1:0]  r_mem [MAX_DIGITS];
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    t_div_stat           div_stat;
    logic                div_load;
    logic                div_start;
    logic                wr_en;
    logic                finish;
    logic [CNT_W-1:0]    cnt_next;
    logic [RADIX_W-1:0]  radix_eff;

    assign radix_eff = eff_radix(r_radix);
    assign o_ready   = (r_state == S_IDLE);
    assign div_load  = i_valid && o_ready;
    assign wr_en     = (r_state == S_DIV) && div_stat.done;
    assign cnt_next  = r_cnt + CNT_W'(1);
    assign finish    = div_stat.zero || (cnt_next == CNT_W'(MAX_DIGITS));
    assign div_start = wr_en && !finish;

    itdab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_value (i_value),
        .i_start (div_start),
        .i_radix (radix_eff),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
            r_sym   <= {SYM3_RST, SYM2_RST, SYM1_RST, SYM0_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIX: r_radix  <= i_cfg_data[RADIX_W-1:0];
                CFG_SYM0:  r_sym[0] <= i_cfg_data;
                CFG_SYM1:  r_sym[1] <= i_cfg_data;
                CFG_SYM2:  r_sym[2] <= i_cfg_data;
                CFG_SYM3:  r_sym[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[PTR_W-1:0]] <= div_stat.digit;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (div_load) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_cnt <= cnt_next;
                        if (finish) begin
                            r_ptr   <= r_cnt[PTR_W-1:0];
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out_char  <= symbol_of(r_sym, r_rd_data);
                    r_out_last  <= (r_ptr == '0);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ptr   <= r_ptr - PTR_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    `ITDAB_ASSERT_IMP(a_no_accept_while_out, i_clk, i_rst_n,
        o_valid, !o_ready, "request accepted while a digit is pending")
    `ITDAB_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n,
        div_stat.done, r_state == S_DIV, "divider finished outside the division phase")
    `ITDAB_ASSERT_IMP(a_last_at_bottom, i_clk, i_rst_n,
        o_valid && o_last_digit, r_ptr == '0, "last digit flagged above the bottom entry")
    `ITDAB_ASSERT_NXT(a_finish_to_read, i_clk, i_rst_n,
        wr_en && finish, r_state == S_RD && r_cnt != '0, "conversion end did not start emission")
    `ITDAB_ASSERT_IMP(a_count_bound, i_clk, i_rst_n,
        r_state == S_OUT, r_cnt <= CNT_W'(MAX_DIGITS) && r_cnt != '0, "digit count out of range")

endmodule
`default_nettype wire
